/* rtl/assert_macros.svh */
// assertion macros shared by the sharpening filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define SHP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* rtl/shp_pkg.sv */
// shared constants and types for the 3x3 sharpening filter
package shp_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;

    // widths
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 12;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 2;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = COL_W;
    localparam int RAM_W   = 2 * PIX_W;
    localparam int ODATA_W = ((SUM_W + 7) / 8) * 8;

    // window cells behind the current column
    localparam int NUM_CELLS = 2;

    // register reset values
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = CFG_W'(1000);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(1000);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_LINE_WIDTH   = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = CIDX_W'(1);

    typedef logic [PIX_W-1:0] t_pixel;

    // one window column: rows r-2, r-1, r
    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    // line store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [RAM_W-1:0]  data;
    } t_ram_wr;

endpackage

/* rtl/shp_line_ram.sv */
// line store memory: middle line in the upper byte, upper line in the lower byte
module shp_line_ram
    import shp_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [RAM_W-1:0]  o_rdata
);

    logic [RAM_W-1:0] r_mem [MAX_WIDTH];
    logic [RAM_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port, old data on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/shp_cell.sv */
// one window cell: holds a three-pixel column and passes it to its neighbour
module shp_cell
    import shp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_column i_col,
    output t_column o_col
);

    t_column r_col;

    // shift in the neighbour's column on each pixel step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

/* rtl/sharpen_3x3_convolution.sv */
// top level of the 3x3 sharpening filter over a raster pixel stream
//
// Input stream: one 8-bit pixel per transaction in raster order on s_axis,
// tuser bit 0 marks the top-left pixel of a frame and restarts counting.
// Output stream: one signed 12-bit kernel sum per interior pixel on m_axis,
// tlast marks the result of the last interior pixel of the frame.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 line width, 1 frame height), both clamped to 3..1024 in use.
// Throughput is one pixel per cycle unless a held result stalls stage one;
// the line store has one read and one write port, with a bypass for
// back-to-back pixels on the same column. A pixel that completes a window
// is read into stage one, then its sum is registered onto m_axis.
// Border pixels advance the pipeline and give no transaction.
// After reset the line store is cleared one column per cycle, all 1024 columns,
// with s_axis_tready low; configuration writes are taken during that time.
// When m_axis stalls, the held result blocks the next result-bearing pixel in
// stage one and all input behind it; pixels with no result flow until then.
module sharpen_3x3_convolution
    import shp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // pixel input
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]         s_axis_tuser,   // [0] first_of_frame
    // filtered output
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [ODATA_W-1:0] m_axis_tdata,   // [11:0] filtered_value, [15:12] zero
    output logic               m_axis_tlast    // last_of_frame
);

    // configuration registers
    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;

    // clearing pass
    logic              r_init_done;
    logic [ADDR_W-1:0] r_clr;

    // position counters
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // stage one: line store data available
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    t_pixel            r_s1_px;
    logic              r_s1_produce;
    logic              r_s1_last;
    logic              r_s1_fwd;
    t_pixel            r_fwd_top;
    t_pixel            r_fwd_mid;

    // output register
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_data;
    logic             r_out_last;

    logic [CFG_W-1:0] w_width;
    logic [CFG_W-1:0] w_height;
    logic             w_accept;
    logic             w_s1_adv;
    logic             w_s1_step;
    logic [COL_W-1:0] w_c_base;
    logic [ROW_W-1:0] w_r_base;
    logic [CFG_W-1:0] w_c_ext;
    logic [CFG_W-1:0] w_r_ext;
    logic [CFG_W-1:0] w_c_inc;
    logic [CFG_W-1:0] w_r_inc;
    logic             w_produce;
    logic             w_last;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [RAM_W-1:0] w_rdata;
    t_pixel           w_top;
    t_pixel           w_mid;
    t_ram_wr          w_wr;
    t_column          w_chain [NUM_CELLS+1];
    logic [SUM_W-1:0] w_center5;
    logic [SUM_W-1:0] w_others;
    logic [SUM_W-1:0] w_sum;

    // register values in use, clamped to the supported range
    always_comb begin
        if (r_line_width < CFG_W'(MIN_DIM)) begin
            w_width = CFG_W'(MIN_DIM);
        end else if (r_line_width > CFG_W'(MAX_WIDTH)) begin
            w_width = CFG_W'(MAX_WIDTH);
        end else begin
            w_width = r_line_width;
        end
        if (r_frame_height < CFG_W'(MIN_DIM)) begin
            w_height = CFG_W'(MIN_DIM);
        end else if (r_frame_height > CFG_W'(MAX_HEIGHT)) begin
            w_height = CFG_W'(MAX_HEIGHT);
        end else begin
            w_height = r_frame_height;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: stage one moves unless it holds a result the output cannot take
    assign w_s1_adv      = !r_s1_produce || !r_out_valid || m_axis_tready;
    assign w_s1_step     = r_s1_valid && w_s1_adv;
    assign s_axis_tready = r_init_done && (!r_s1_valid || w_s1_adv);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // position of this pixel and of the next one
    always_comb begin
        w_c_base  = s_axis_tuser[0] ? '0 : r_col;
        w_r_base  = s_axis_tuser[0] ? '0 : r_row;
        w_c_ext   = CFG_W'(w_c_base);
        w_r_ext   = CFG_W'(w_r_base);
        w_produce = (w_r_ext >= CFG_W'(2)) && (w_c_ext >= CFG_W'(2)) &&
                    (w_r_ext < w_height) && (w_c_ext < w_width);
        w_last    = (w_r_ext == w_height - CFG_W'(1)) &&
                    (w_c_ext == w_width - CFG_W'(1));
        w_c_inc   = w_c_ext + CFG_W'(1);
        w_r_inc   = w_r_ext + CFG_W'(1);
        n_col     = w_c_inc[COL_W-1:0];
        n_row     = w_r_base;
        if (w_c_inc >= w_width) begin
            n_col = '0;
            n_row = w_r_inc[ROW_W-1:0];
            if (w_r_inc >= w_height) begin
                n_row = '0;
            end
        end
    end

    // counters advance on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // clearing pass over the line store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_done <= 1'b0;
            r_clr       <= '0;
        end else if (!r_init_done) begin
            r_clr <= r_clr + ADDR_W'(1);
            if (r_clr == ADDR_W'(MAX_WIDTH - 1)) begin
                r_init_done <= 1'b1;
            end
        end
    end

    // line store pixels for stage one, bypassing the write made on the same edge
    assign w_top = r_s1_fwd ? r_fwd_top : w_rdata[PIX_W-1:0];
    assign w_mid = r_s1_fwd ? r_fwd_mid : w_rdata[RAM_W-1:PIX_W];

    // write port: clearing pass or column update from stage one
    always_comb begin
        if (!r_init_done) begin
            w_wr.we   = 1'b1;
            w_wr.addr = r_clr;
            w_wr.data = '0;
        end else begin
            w_wr.we   = w_s1_step;
            w_wr.addr = r_s1_addr;
            w_wr.data = {r_s1_px, w_mid};
        end
    end

    shp_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_re    (w_accept),
        .i_raddr (w_c_base),
        .o_rdata (w_rdata)
    );

    // stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr    <= w_c_base;
            r_s1_px      <= s_axis_tdata;
            r_s1_produce <= w_produce;
            r_s1_last    <= w_last;
            r_s1_fwd     <= r_s1_valid && (r_s1_addr == w_c_base);
            r_fwd_top    <= w_mid;
            r_fwd_mid    <= r_s1_px;
        end
    end

    // window: current column feeds the chain of cells
    assign w_chain[0] = '{top: w_top, mid: w_mid, bot: r_s1_px};

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        shp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_s1_step),
            .i_col   (w_chain[k]),
            .o_col   (w_chain[k+1])
        );
    end

    // kernel: five times the centre minus the eight neighbours
    always_comb begin
        w_center5 = SUM_W'({w_chain[1].mid, 2'b00}) + SUM_W'(w_chain[1].mid);
        w_others  = SUM_W'(w_chain[2].top) + SUM_W'(w_chain[2].mid) +
                    SUM_W'(w_chain[2].bot) + SUM_W'(w_chain[1].top) +
                    SUM_W'(w_chain[1].bot) + SUM_W'(w_chain[0].top) +
                    SUM_W'(w_chain[0].mid) + SUM_W'(w_chain[0].bot);
        w_sum     = w_center5 - w_others;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_step && r_s1_produce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_step && r_s1_produce) begin
            r_out_data <= w_sum;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODATA_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

    // checks on the pipeline
    `include "assert_macros.svh"

    `SHP_NEVER(a_no_pixel_during_clear, r_s1_valid && !r_init_done, "pixel in pipe during clear")
    `SHP_ASSERT(a_result_lands, (w_s1_step && r_s1_produce) |=> r_out_valid, "result lost")
    `SHP_ASSERT(a_last_has_result, (r_s1_valid && r_s1_last) |-> r_s1_produce, "stray last flag")
    `SHP_ASSERT(a_held_result_kept, (r_out_valid && !m_axis_tready) |=> r_out_valid, "result dropped")

endmodule

/* dv/sharpen_tb_pkg.sv */
// scoreboard class that predicts and checks the sharpening filter results
package sharpen_tb_pkg;
    import shp_pkg::*;

    // register indexes the block does not decode
    localparam logic [CIDX_W-1:0] REG_SPARE_LO = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = CIDX_W'(3);

    // one expected output transaction
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
    } t_filtered;

    class sharpen_tracker;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_pixel           upper_row[MAX_WIDTH];
        t_pixel           middle_row[MAX_WIDTH];
        // [0..2] column c-2, [3..5] column c-1; rows top, mid, bottom
        t_pixel           window[6];
        int unsigned      col;
        int unsigned      row;
        t_filtered        awaited_sums[$];
        int               errors;

        function new();
            width_reg  = LINE_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        // register value as the block uses it
        function int unsigned clamp_dim(logic [CFG_W-1:0] raw, int unsigned hi);
            if (raw < MIN_DIM) return MIN_DIM;
            if (raw > hi) return hi;
            return 32'(raw);
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function int pending();
            return awaited_sums.size();
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_LINE_WIDTH) width_reg = data;
            else if (idx == REG_FRAME_HEIGHT) height_reg = data;
        endfunction

        // advance the line stores and window by one accepted pixel
        function void take_pixel(t_pixel px, logic first);
            int unsigned w;
            int unsigned h;
            int unsigned ci;
            t_pixel      top;
            t_pixel      mid;
            int          others;
            int          total;
            t_filtered   res;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            if (first) begin
                col = 0;
                row = 0;
            end
            ci  = col % MAX_WIDTH;
            top = upper_row[ci];
            mid = middle_row[ci];
            upper_row[ci]  = mid;
            middle_row[ci] = px;

            // interior window complete: centre weight 5, neighbours -1
            if (row >= 2 && col >= 2 && row < h && col < w) begin
                others = int'(window[0]) + int'(window[1]) + int'(window[2])
                       + int'(window[3]) + int'(window[5])
                       + int'(top) + int'(mid) + int'(px);
                total    = 5 * int'(window[4]) - others;
                res.sum  = total[SUM_W-1:0];
                res.last = (row == h - 1 && col == w - 1);
                awaited_sums.push_back(res);
            end

            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top;
            window[4] = mid;
            window[5] = px;

            // raster position with wrap at row and frame end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        // compare one output transaction with the oldest expected sum
        function void check_sum(logic [ODATA_W-1:0] data, logic last);
            t_filtered want;
            if (awaited_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual sum %0d last %0b",
                         $time, $signed(data[SUM_W-1:0]), last);
                return;
            end
            want = awaited_sums.pop_front();
            if (data[SUM_W-1:0] !== want.sum) begin
                errors++;
                $display("%0t: sum mismatch, expected %0d, actual %0d",
                         $time, $signed(want.sum), $signed(data[SUM_W-1:0]));
            end
            if (data[ODATA_W-1:SUM_W] !== '0) begin
                errors++;
                $display("%0t: tdata padding mismatch, expected 0, actual %0h",
                         $time, data[ODATA_W-1:SUM_W]);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: tlast mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

endpackage

/* dv/tb.sv */
// top-level testbench driving the sharpening filter through directed and random frames
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import shp_pkg::*;
    import sharpen_tb_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 500;
    localparam int TALL_ITEMS    = 90;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata;   // [7:0] pixel
    logic [0:0]         s_axis_tuser;   // [0] first_of_frame
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [ODATA_W-1:0] m_axis_tdata;   // [11:0] filtered_value, [15:12] zero
    logic               m_axis_tlast;   // last_of_frame

    sharpen_tracker tracker = new();
    int             in_gap_max  = 0;
    int             out_gap_max = 0;
    int             cycles      = 0;

    sharpen_3x3_convolution uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // pixel value biased towards the extremes
    function automatic t_pixel any_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    // idle bound for one phase: none, short or long gaps
    function automatic int gap_choice();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 16;
        endcase
    endfunction

    // one input transaction after a random gap
    task automatic send_pixel(input t_pixel px, input logic first);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_pixel(px, first);
    endtask

    // whole frames, frame start flagged always on the first, sometimes later
    task automatic send_frames(input int frames);
        int unsigned n;
        n = tracker.frame_pixels();
        for (int f = 0; f < frames; f++) begin
            for (int unsigned p = 0; p < n; p++) begin
                send_pixel(any_pixel(), p == 0 && (f == 0 || $urandom_range(0, 1) == 1));
            end
        end
    endtask

    // leaves the write enable high; configure lowers it
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // register writes in random order, optionally with a write to a spare index
    task automatic configure(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                             input bit spare);
        if (spare) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_W'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 1)) begin
            write_reg(REG_LINE_WIDTH, w_raw);
            write_reg(REG_FRAME_HEIGHT, h_raw);
        end else begin
            write_reg(REG_FRAME_HEIGHT, h_raw);
            write_reg(REG_LINE_WIDTH, w_raw);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and wait for every expected result plus pipeline flush
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side: random back-pressure, check each transaction
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            tracker.check_sum(m_axis_tdata, m_axis_tlast);
        end
    end

    // stimulus
    initial begin
        int               sent_random;
        int               pick;
        int               len;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        sent_random = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_LINE_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a few pixels under the reset geometry, then shrink to 3x3 mid-row
        for (int i = 0; i < 6; i++) send_pixel(i[0] ? '1 : '0, i == 0);
        drain();
        configure(CFG_W'(3), CFG_W'(3), 1'b0);
        // count past the new width: no result, wraps
        send_pixel('1, 1'b0);
        // largest sum: bright centre on black
        for (int i = 0; i < 9; i++) send_pixel(i == 4 ? '1 : '0, i == 0);
        // smallest sum, frame reached by wrap without a start flag
        for (int i = 0; i < 9; i++) send_pixel(i == 4 ? '0 : '1, 1'b0);
        drain();

        // random phases: mostly whole frames, some noise with stray frame starts
        while (sent_random < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 9);
            w_raw = CFG_W'($urandom_range(3, 12));
            h_raw = CFG_W'($urandom_range(3, 8));
            if (pick == 0) w_raw = CFG_W'($urandom_range(0, 3));
            else if (pick == 1) h_raw = CFG_W'($urandom_range(0, 3));
            configure(w_raw, h_raw, $urandom_range(0, 3) == 0);
            in_gap_max  = gap_choice();
            out_gap_max = gap_choice();
            if ($urandom_range(0, 3) != 0) begin
                len = $urandom_range(1, 3);
                send_frames(len);
                sent_random += len * tracker.frame_pixels();
            end else begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++) send_pixel(any_pixel(), $urandom_range(0, 15) == 0);
                sent_random += len;
            end
            drain();
        end

        // widest rows (clamped from above), height clamped from below:
        // two narrow rows reach row 2, then one full-width row ends the frame
        in_gap_max  = gap_choice();
        out_gap_max = gap_choice();
        configure(CFG_W'(3), CFG_W'(0), 1'b1);
        for (int i = 0; i < 6; i++) send_pixel(any_pixel(), i == 0);
        drain();
        configure(CFG_W'(2047), CFG_W'(0), 1'b0);
        for (int i = 0; i < MAX_WIDTH; i++) send_pixel(any_pixel(), 1'b0);
        drain();
        // tall frame clamped from above, narrowest rows: first rows only
        in_gap_max  = gap_choice();
        out_gap_max = gap_choice();
        configure(CFG_W'(3), CFG_W'(2047), 1'b0);
        for (int i = 0; i < TALL_ITEMS; i++) send_pixel(any_pixel(), i == 0);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
